// ===== rtl/lzsd_pkg.sv =====
// shared constants and helpers for the lz stream decompressor
// no dependencies; used by the top level and its port checker
`default_nettype none
package lzsd_pkg;

  localparam int unsigned WindowBytes = 65536;
  localparam int unsigned HistAw      = $clog2(WindowBytes);
  localparam int unsigned CntW        = 17;
  localparam int unsigned DistW       = 25;
  localparam logic [16:0] AdlerMod    = 17'd65521;
  localparam logic [31:0] HdrMagic    = 32'h57BC_0000;
  localparam logic [7:0]  EndMark     = 8'hFA;

  localparam logic [3:0] ST_OK     = 4'd0;
  localparam logic [3:0] ST_HEADER = 4'd1;
  localparam logic [3:0] ST_TRUNC  = 4'd2;
  localparam logic [3:0] ST_TOKEN  = 4'd3;
  localparam logic [3:0] ST_DIST   = 4'd4;
  localparam logic [3:0] ST_OVER   = 4'd5;
  localparam logic [3:0] ST_MARKER = 4'd6;
  localparam logic [3:0] ST_SHORT  = 4'd7;
  localparam logic [3:0] ST_CHECK  = 4'd8;
  localparam logic [3:0] ST_BUSY   = 4'd9;

  // bytes in a token, from its first byte; zero for an illegal opcode
  function automatic logic [2:0] token_need(input logic [7:0] t);
    logic [2:0] n;
    if (t >= 8'h80)      n = 3'd2;
    else if (t >= 8'h40) n = 3'd3;
    else if (t >= 8'h20) n = 3'd1;
    else if (t >= 8'h18) n = 3'd4;
    else if (t >= 8'h10) n = 3'd5;
    else if (t >= 8'h08) n = 3'd2;
    else if (t == 8'h07) n = 3'd3;
    else if (t == 8'h06) n = 3'd5;
    else if (t == 8'h05 || t == 8'h04) n = 3'd6;
    else n = 3'd0;
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lz_stream_decompressor.sv =====
// lz stream decompressor top level: header check, token parser, history memory, adler-32
// depends on lzsd_pkg
`default_nettype none
// Takes one word per clock when not stalled: a compressed byte (tuser 0) or a copy
// tick (tuser 1). Each accepted word gives at most one result word, through the
// internal and output stages, in order; a full output register does not block input
// until the single internal stage behind it is also full. Throughput is likewise one
// word per cycle, including copy ticks: each tick reads the 64 KiB history memory
// once through its one read port (with forwarding of the byte being written in the
// same cycle) and the output stage writes it back once. Errors end the stream with a
// status word (tuser 1, tlast 1); after it all input is dropped until reset.
module lz_stream_decompressor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] in_byte
  input  wire logic        s_tuser_i,   // [0] action
  input  wire logic        s_tlast_i,   // in_last
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [15:0]      m_tdata_o,   // [7:0] data_byte, [11:8] status, [15:12] zero
  output logic             m_tuser_o,   // [0] kind
  output logic             m_tlast_o    // stream_end
);

  localparam int unsigned Aw   = lzsd_pkg::HistAw;
  localparam int unsigned Cw   = lzsd_pkg::CntW;
  localparam int unsigned Dw   = lzsd_pkg::DistW;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TOKEN   = 3'd1;
  localparam logic [2:0] PH_LITERAL = 3'd2;
  localparam logic [2:0] PH_COPY    = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [1:0] RK_LIT    = 2'd0;
  localparam logic [1:0] RK_COPY   = 2'd1;
  localparam logic [1:0] RK_STATUS = 2'd2;
  localparam logic [1:0] RK_ENDCHK = 2'd3;

  // parser state
  logic [2:0]    phase_q, phase_d;
  logic [3:0]    pos_q, pos_d;
  logic [7:0]    tb_q [5];
  logic [7:0]    tb_d [5];
  logic [Cw-1:0] bw_q, bw_d, exp_q, exp_d, lit_q, lit_d, cdist_q, cdist_d, crem_q, crem_d;

  // output-side stage
  logic          p_valid_q;
  logic [1:0]    p_kind_q;
  logic [7:0]    p_byte_q;
  logic [3:0]    p_status_q;
  logic [31:0]   p_cksum_q;
  logic [Aw-1:0] p_waddr_q;
  logic          p_hit_q;
  logic [7:0]    p_fwd_q;
  logic [15:0]   sl_q, sh_q;

  logic          o_valid_q;
  logic          o_kind_q;
  logic [7:0]    o_byte_q;
  logic [3:0]    o_status_q;

  logic [7:0]    hist_mem [lzsd_pkg::WindowBytes];
  logic [7:0]    rdata_q;

  logic          acc, tick, p_adv, p_wr;
  logic          res, rd_en;
  logic [1:0]    res_kind;
  logic [3:0]    res_status;
  logic [Cw-1:0] rd_diff;
  logic [Aw-1:0] rd_addr;

  assign p_adv      = p_valid_q && (!o_valid_q || m_tready_i);
  assign s_tready_o = !p_valid_q || p_adv;
  assign acc        = s_tvalid_i && s_tready_o;
  assign tick       = s_tuser_i;
  assign p_wr       = p_adv && (p_kind_q == RK_LIT || p_kind_q == RK_COPY);
  assign rd_diff    = bw_q - cdist_q;
  assign rd_addr    = Aw'(rd_diff);

  // token field decode
  logic [7:0]    b [6];
  logic [7:0]    first;
  logic [2:0]    need;
  logic [Dw-1:0] tk_dist;
  logic [Cw-1:0] tk_len;
  logic          tk_lit, tk_end, dist_bad, over;
  logic [Cw:0]   room;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (i < 5 && 4'(i) < pos_q) b[i] = tb_q[i < 5 ? i : 0];
      else if (4'(i) == pos_q)    b[i] = s_tdata_i;
      else                        b[i] = 8'h00;
    end
    first   = (pos_q == 4'd0) ? s_tdata_i : tb_q[0];
    need    = lzsd_pkg::token_need(first);
    tk_lit  = 1'b0;
    tk_end  = 1'b0;
    tk_dist = '0;
    tk_len  = '0;
    if (b[0] >= 8'h80) begin
      tk_dist = Dw'(b[1]) + Dw'(1);
      tk_len  = Cw'(b[0][6:0]) + Cw'(1);
    end else if (b[0] >= 8'h40) begin
      tk_dist = Dw'({b[0][5:0], b[1]}) + Dw'(1);
      tk_len  = Cw'(b[2]) + Cw'(1);
    end else if (b[0] >= 8'h20) begin
      tk_lit  = 1'b1;
      tk_len  = Cw'(b[0][4:0]) + Cw'(1);
    end else if (b[0] >= 8'h18) begin
      tk_dist = Dw'({b[0][2:0], b[1], b[2]}) + Dw'(1);
      tk_len  = Cw'(b[3]) + Cw'(1);
    end else if (b[0] >= 8'h10) begin
      tk_dist = Dw'({b[0][2:0], b[1], b[2]}) + Dw'(1);
      tk_len  = Cw'({b[3], b[4]}) + Cw'(1);
    end else if (b[0] >= 8'h08) begin
      tk_lit  = 1'b1;
      tk_len  = Cw'({b[0][2:0], b[1]}) + Cw'(1);
    end else if (b[0] == 8'h07) begin
      tk_lit  = 1'b1;
      tk_len  = Cw'({b[1], b[2]}) + Cw'(1);
    end else if (b[0] == 8'h06) begin
      tk_dist = Dw'({b[1], b[2], b[3]}) + Dw'(1);
      tk_len  = Cw'(b[4]) + Cw'(1);
    end else if (b[0] == 8'h04) begin
      tk_dist = Dw'({b[1], b[2], b[3]}) + Dw'(1);
      tk_len  = Cw'({b[4], b[5]}) + Cw'(1);
    end else begin
      tk_end  = 1'b1;
    end
    dist_bad = (tk_dist > Dw'(bw_q)) || (tk_dist > Dw'(lzsd_pkg::WindowBytes));
    room     = {1'b0, exp_q} - {1'b0, bw_q};
    over     = !room[Cw] && (tk_len > room[Cw-1:0]);
  end

  // parser: control state advances as each word is accepted
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tb_d       = tb_q;
    bw_d       = bw_q;
    exp_d      = exp_q;
    lit_d      = lit_q;
    cdist_d    = cdist_q;
    crem_d     = crem_q;
    res        = 1'b0;
    res_kind   = RK_STATUS;
    res_status = lzsd_pkg::ST_OK;
    rd_en      = 1'b0;
    if (acc) begin
      unique case (phase_q)
        PH_COPY: begin
          if (tick) begin
            rd_en    = 1'b1;
            res      = 1'b1;
            res_kind = RK_COPY;
            bw_d     = bw_q + Cw'(1);
            crem_d   = crem_q - Cw'(1);
            if (crem_q == Cw'(1)) phase_d = PH_TOKEN;
          end else begin
            res = 1'b1; res_status = lzsd_pkg::ST_BUSY;
          end
        end
        PH_LITERAL: begin
          if (!tick) begin
            if (s_tlast_i) begin
              res = 1'b1; res_status = lzsd_pkg::ST_TRUNC;
            end else begin
              res      = 1'b1;
              res_kind = RK_LIT;
              bw_d     = bw_q + Cw'(1);
              lit_d    = lit_q - Cw'(1);
              if (lit_q == Cw'(1)) phase_d = PH_TOKEN;
            end
          end
        end
        PH_HEADER: begin
          if (!tick) begin
            if (s_tlast_i) begin
              res = 1'b1; res_status = lzsd_pkg::ST_TRUNC;
            end else if (pos_q < 4'd4 &&
                         s_tdata_i != lzsd_pkg::HdrMagic[8*(3-pos_q[1:0]) +: 8]) begin
              res = 1'b1; res_status = lzsd_pkg::ST_HEADER;
            end else if (pos_q >= 4'd4 && pos_q < 4'd9 && s_tdata_i != 8'h00) begin
              res = 1'b1; res_status = lzsd_pkg::ST_HEADER;
            end else if (pos_q == 4'd9 && s_tdata_i > 8'h01) begin
              res = 1'b1; res_status = lzsd_pkg::ST_HEADER;
            end else begin
              if (pos_q == 4'd9) exp_d = Cw'(s_tdata_i);
              else if (pos_q == 4'd10 || pos_q == 4'd11) exp_d = {exp_q[Cw-9:0], s_tdata_i};
              if (pos_q == 4'd15) begin
                pos_d   = 4'd0;
                phase_d = PH_TOKEN;
              end else begin
                pos_d = pos_q + 4'd1;
              end
            end
          end
        end
        PH_TOKEN: begin
          if (!tick) begin
            if (need == 3'd0) begin
              res = 1'b1; res_status = lzsd_pkg::ST_TOKEN;
            end else if ((pos_q + 4'd1) < 4'(need) && s_tlast_i) begin
              res = 1'b1; res_status = lzsd_pkg::ST_TRUNC;
            end else if (first == 8'h05 && pos_q == 4'd1 && s_tdata_i != lzsd_pkg::EndMark) begin
              res = 1'b1; res_status = lzsd_pkg::ST_MARKER;
            end else if ((pos_q + 4'd1) < 4'(need)) begin
              tb_d[pos_q[2:0]] = s_tdata_i;
              pos_d            = pos_q + 4'd1;
            end else begin
              pos_d = 4'd0;
              if (tk_end) begin
                res = 1'b1;
                if (bw_q != exp_q) res_status = lzsd_pkg::ST_SHORT;
                else res_kind = RK_ENDCHK;
              end else if (tk_lit) begin
                if (s_tlast_i) begin
                  res = 1'b1; res_status = lzsd_pkg::ST_TRUNC;
                end else if (over) begin
                  res = 1'b1; res_status = lzsd_pkg::ST_OVER;
                end else begin
                  lit_d   = tk_len;
                  phase_d = PH_LITERAL;
                end
              end else if (dist_bad) begin
                res = 1'b1; res_status = lzsd_pkg::ST_DIST;
              end else if (over) begin
                res = 1'b1; res_status = lzsd_pkg::ST_OVER;
              end else if (s_tlast_i) begin
                res = 1'b1; res_status = lzsd_pkg::ST_TRUNC;
              end else begin
                cdist_d = Cw'(tk_dist);
                crem_d  = tk_len;
                phase_d = PH_COPY;
              end
            end
          end
        end
        default: ;
      endcase
      if (res && (res_kind == RK_STATUS || res_kind == RK_ENDCHK)) phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      for (int i = 0; i < 5; i++) tb_q[i] <= '0;
      bw_q    <= '0;
      exp_q   <= '0;
      lit_q   <= '0;
      cdist_q <= '0;
      crem_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tb_q    <= tb_d;
      bw_q    <= bw_d;
      exp_q   <= exp_d;
      lit_q   <= lit_d;
      cdist_q <= cdist_d;
      crem_q  <= crem_d;
    end
  end

  // history memory, one write and one read port
  logic [7:0] out_byte;

  always_ff @(posedge clk_i) begin
    if (p_wr) hist_mem[p_waddr_q] <= out_byte;
    if (rd_en) rdata_q <= hist_mem[rd_addr];
  end

  // stage after acceptance: data byte, history write, checksum
  logic [16:0] sl_sum, sh_sum;
  logic [15:0] sl_new, sh_new;
  logic [3:0]  out_status;

  always_comb begin
    out_byte = (p_kind_q == RK_COPY) ? (p_hit_q ? p_fwd_q : rdata_q) : p_byte_q;
    sl_sum   = {1'b0, sl_q} + 17'(out_byte);
    sl_new   = (sl_sum >= lzsd_pkg::AdlerMod) ? 16'(sl_sum - lzsd_pkg::AdlerMod) : sl_sum[15:0];
    sh_sum   = {1'b0, sh_q} + {1'b0, sl_new};
    sh_new   = (sh_sum >= lzsd_pkg::AdlerMod) ? 16'(sh_sum - lzsd_pkg::AdlerMod) : sh_sum[15:0];
    if (p_kind_q == RK_ENDCHK)
      out_status = ({sh_q, sl_q} == p_cksum_q) ? lzsd_pkg::ST_OK : lzsd_pkg::ST_CHECK;
    else
      out_status = p_status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      sl_q      <= 16'd1;
      sh_q      <= 16'd0;
    end else begin
      if (acc) p_valid_q <= res;
      else if (p_adv) p_valid_q <= 1'b0;
      if (p_adv) o_valid_q <= 1'b1;
      else if (m_tready_i) o_valid_q <= 1'b0;
      if (p_wr) begin
        sl_q <= sl_new;
        sh_q <= sh_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_kind_q   <= res_kind;
      p_byte_q   <= s_tdata_i;
      p_status_q <= res_status;
      p_cksum_q  <= {b[2], b[3], b[4], b[5]};
      p_waddr_q  <= Aw'(bw_q);
      // byte written this edge is not yet visible on the read port
      p_hit_q    <= p_wr && (p_waddr_q == rd_addr);
      p_fwd_q    <= out_byte;
    end
    if (p_adv) begin
      o_kind_q   <= (p_kind_q == RK_STATUS || p_kind_q == RK_ENDCHK);
      o_byte_q   <= (p_kind_q == RK_LIT || p_kind_q == RK_COPY) ? out_byte : 8'h00;
      o_status_q <= (p_kind_q == RK_LIT || p_kind_q == RK_COPY) ? lzsd_pkg::ST_OK : out_status;
    end
  end

  assign m_tvalid_o = o_valid_q;
  assign m_tdata_o  = {4'h0, o_status_q, o_byte_q};
  assign m_tuser_o  = o_kind_q;
  assign m_tlast_o  = o_kind_q;

endmodule
`default_nettype wire

// ===== rtl/lzsd_port_checker.sv =====
// port-level checker for the lz stream decompressor, bound to the top level
// depends on lzsd_pkg and lz_stream_decompressor
`default_nettype none
module lzsd_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [15:0] m_tdata_o,
  input wire logic        m_tuser_o,
  input wire logic        m_tlast_o
);

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else if (m_tvalid_o && m_tready_i && m_tlast_o) done_q <= 1'b1;
  end

  // nothing follows the status word
  a_none_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && m_tvalid_o)) else $error("word after stream end");

  // status word is exactly the one that ends the stream
  a_end_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tlast_o == m_tuser_o)) else $error("tlast and tuser disagree");

  // data words carry ok, status words a defined code and no data
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> (m_tdata_o[11:8] == lzsd_pkg::ST_OK))
    else $error("data word with status");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tdata_o[11:8] <= lzsd_pkg::ST_BUSY &&
                                   m_tdata_o[7:0] == 8'h00))
    else $error("bad status word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("stalled word changed");

endmodule

bind lz_stream_decompressor lzsd_port_checker u_lzsd_port_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);
`default_nettype wire
